FILE: sv/irbl_pkg.sv
// Shared types and constants for the IPv4 range bucket lookup core.
// Used by every module of the block except irbl_ram; depends on nothing else.
`default_nettype none
package irbl_pkg;

	localparam int RECORD_DEPTH = 524288;
	localparam int BUCKET_DEPTH = 65536;

	localparam int OPC_W = 2;
	localparam int SLOT_W = 19;
	localparam int BSTART_W = 20;
	localparam int IP_W = 32;
	localparam int OFF_W = 24;
	localparam int LEN_W = 16;
	localparam int LOC_W = OFF_W + LEN_W;
	localparam int RECNO_W = 19;

	localparam int RCNT_W = 20;
	localparam int DEND_W = 25;
	localparam int CAP_W = 17;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [OPC_W-1:0] OP_WR_BUCKET = 2'd0;
	localparam logic [OPC_W-1:0] OP_WR_RECORD = 2'd1;
	localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_RECORD_COUNT = 2'd1;
	localparam logic [1:0] REG_DATA_END = 2'd2;
	localparam logic [1:0] REG_OUT_CAPACITY = 2'd3;

	localparam logic MODE_RESET = 1'b1;
	localparam logic [RCNT_W-1:0] RECORD_COUNT_RESET = '0;
	localparam logic [DEND_W-1:0] DATA_END_RESET = '0;
	localparam logic [CAP_W-1:0] OUT_CAPACITY_RESET = 17'd512;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BKT,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic mode;
		logic [RCNT_W-1:0] record_count;
		logic [DEND_W-1:0] data_end;
		logic [CAP_W-1:0] out_capacity;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic load_idx;
		logic scan;
		logic capture;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic bkt_ok;
		logic in_range;
		logic pend;
		logic hit;
	} ctl_sts_t;

endpackage
`default_nettype wire

FILE: sv/irbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module irbl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/irbl_ctrl.sv
// Lookup sequencer: drives the datapath through bucket read, scan and result.
// Depends on irbl_pkg.
`default_nettype none
module irbl_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [irbl_pkg::OPC_W-1:0] opcode,
	input  wire irbl_pkg::ctl_sts_t         sts,
	output irbl_pkg::ctl_cmd_t              cmd,
	output logic                            busy
);

	irbl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irbl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			irbl_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					if (opcode == irbl_pkg::OP_LOOKUP) begin
						state_d = irbl_pkg::ST_BKT;
					end
				end
			end
			irbl_pkg::ST_BKT: begin
				if (sts.bkt_ok) begin
					cmd.load_idx = 1'b1;
					state_d = irbl_pkg::ST_SCAN;
				end else begin
					state_d = irbl_pkg::ST_EMIT;
				end
			end
			irbl_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.capture = 1'b1;
					state_d = irbl_pkg::ST_EMIT;
				end else if (!sts.pend && !sts.in_range) begin
					state_d = irbl_pkg::ST_EMIT;
				end
			end
			irbl_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = irbl_pkg::ST_IDLE;
			end
			default: begin
				state_d = irbl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/irbl_dp.sv
// Lookup datapath: bucket and record tables, scan index, hit capture, result.
// Depends on irbl_pkg and irbl_ram.
`default_nettype none
module irbl_dp #(
	parameter int RECORD_DEPTH = irbl_pkg::RECORD_DEPTH,
	parameter int BUCKET_DEPTH = irbl_pkg::BUCKET_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire irbl_pkg::cfg_t                cfg,
	input  wire irbl_pkg::ctl_cmd_t            cmd,
	output irbl_pkg::ctl_sts_t                 sts,
	input  wire logic [irbl_pkg::OPC_W-1:0]    opcode,
	input  wire logic [irbl_pkg::SLOT_W-1:0]   slot,
	input  wire logic [irbl_pkg::BSTART_W-1:0] bucket_start,
	input  wire logic [irbl_pkg::IP_W-1:0]     range_end_ip,
	input  wire logic [irbl_pkg::OFF_W-1:0]    record_data_offset,
	input  wire logic [irbl_pkg::LEN_W-1:0]    record_data_length,
	input  wire logic [irbl_pkg::IP_W-1:0]     lookup_ip,
	output logic                               done,
	output logic                               found,
	output logic                               status,
	output logic [irbl_pkg::OFF_W-1:0]         data_offset,
	output logic [irbl_pkg::LEN_W-1:0]         copy_length,
	output logic [irbl_pkg::RECNO_W-1:0]       record_number
);

	localparam int RAW = $clog2(RECORD_DEPTH);
	localparam int BAW = $clog2(BUCKET_DEPTH);
	localparam int CW = (RAW > irbl_pkg::RCNT_W) ? RAW : irbl_pkg::RCNT_W;
	localparam int CW1 = CW + 1;
	localparam int SW = 25;

	logic [15:0]                     bucket_idx;
	logic                            bkt_we, rec_we;
	logic [irbl_pkg::BSTART_W-1:0]   bkt_rd;
	logic [irbl_pkg::IP_W-1:0]       re_rd;
	logic [irbl_pkg::LOC_W-1:0]      loc_rd;
	logic [CW-1:0]                   slot_ext;

	logic [irbl_pkg::IP_W-1:0]       ip_q;
	logic                            bkt_ok_q;
	logic [CW-1:0]                   idx_q;
	logic                            pend_s1;
	logic [CW-1:0]                   pidx_s1;
	logic                            found_q;
	logic [irbl_pkg::RECNO_W-1:0]    hit_idx_q;
	logic [irbl_pkg::LOC_W-1:0]      loc_q;

	logic [irbl_pkg::OFF_W-1:0]      hit_off;
	logic [irbl_pkg::LEN_W-1:0]      hit_len;
	logic [SW-1:0]                   bound_sum;
	logic                            over;
	logic [irbl_pkg::CAP_W-1:0]      lim;
	logic [irbl_pkg::LEN_W-1:0]      len_clamped;

	assign bucket_idx = cfg.mode ? lookup_ip[31:16] : {8'd0, lookup_ip[31:24]};
	assign slot_ext = CW'(slot);

	assign bkt_we = cmd.accept && (opcode == irbl_pkg::OP_WR_BUCKET)
		&& (20'(slot) < 20'(BUCKET_DEPTH));
	assign rec_we = cmd.accept && (opcode == irbl_pkg::OP_WR_RECORD)
		&& (CW1'(slot) < CW1'(RECORD_DEPTH));

	irbl_ram #(.WIDTH(irbl_pkg::BSTART_W), .DEPTH(BUCKET_DEPTH)) u_bkt_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (slot[BAW-1:0]),
		.wdata (bucket_start),
		.raddr (bucket_idx[BAW-1:0]),
		.rdata (bkt_rd)
	);

	irbl_ram #(.WIDTH(irbl_pkg::IP_W), .DEPTH(RECORD_DEPTH)) u_end_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (slot_ext[RAW-1:0]),
		.wdata (range_end_ip),
		.raddr (idx_q[RAW-1:0]),
		.rdata (re_rd)
	);

	irbl_ram #(.WIDTH(irbl_pkg::LOC_W), .DEPTH(RECORD_DEPTH)) u_loc_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (slot_ext[RAW-1:0]),
		.wdata ({record_data_length, record_data_offset}),
		.raddr (idx_q[RAW-1:0]),
		.rdata (loc_rd)
	);

	assign sts.bkt_ok = bkt_ok_q;
	assign sts.in_range = (idx_q < CW'(cfg.record_count))
		&& ({1'b0, idx_q} < CW1'(RECORD_DEPTH));
	assign sts.pend = pend_s1;
	assign sts.hit = pend_s1 && (re_rd >= ip_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ip_q <= lookup_ip;
			bkt_ok_q <= (17'(bucket_idx) < 17'(BUCKET_DEPTH));
		end
		if (cmd.load_idx) begin
			idx_q <= CW'(bkt_rd);
		end else if (cmd.scan && sts.in_range) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.scan) begin
			pidx_s1 <= idx_q;
		end
		if (cmd.capture) begin
			hit_idx_q <= pidx_s1[irbl_pkg::RECNO_W-1:0];
			loc_q <= loc_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
			done <= 1'b0;
		end else begin
			if (cmd.load_idx) begin
				pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				pend_s1 <= sts.in_range;
			end
			if (cmd.accept) begin
				found_q <= 1'b0;
			end else if (cmd.capture) begin
				found_q <= 1'b1;
			end
			done <= cmd.emit;
		end
	end

	assign hit_off = loc_q[irbl_pkg::OFF_W-1:0];
	assign hit_len = loc_q[irbl_pkg::LOC_W-1:irbl_pkg::OFF_W];
	assign bound_sum = SW'(hit_off) + SW'(hit_len);
	assign over = cfg.mode && (bound_sum > cfg.data_end);
	assign lim = (cfg.out_capacity == '0) ? '0 : cfg.out_capacity - 1'b1;
	assign len_clamped = (irbl_pkg::CAP_W'(hit_len) > lim)
		? lim[irbl_pkg::LEN_W-1:0] : hit_len;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found <= found_q;
			status <= found_q && over;
			data_offset <= found_q ? hit_off : '0;
			copy_length <= (found_q && !over) ? len_clamped : '0;
			record_number <= found_q ? hit_idx_q : '0;
		end
	end

endmodule
`default_nettype wire

FILE: sv/ip_range_bucket_lookup_core.sv
// Top level of the IPv4 range bucket lookup core: APB registers, sequencer, datapath.
// Depends on irbl_pkg, irbl_ctrl, irbl_dp and irbl_ram.
//
// Table writes (bucket start, range record) are taken while idle and leave busy low. A
// lookup reads the bucket table, then scans range records one per cycle from the
// bucket's first record, set by the scan loop over the record RAM read port. A hit ends
// the scan; a miss ends it at the record count or the table end, also at once when the
// bucket's first record is already past that end. busy stays high until the done strobe
// cycle. The result is shown for exactly one cycle with done high; the receiver cannot stall
// it, and a new item may be started in that same cycle.
`default_nettype none
module ip_range_bucket_lookup_core #(
	parameter int RECORD_DEPTH = irbl_pkg::RECORD_DEPTH,
	parameter int BUCKET_DEPTH = irbl_pkg::BUCKET_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [irbl_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [irbl_pkg::PDATA_W-1:0]    pwdata,
	output logic      [irbl_pkg::PDATA_W-1:0]    prdata,
	output logic                                 pready,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [irbl_pkg::OPC_W-1:0]      opcode,
	input  wire logic [irbl_pkg::SLOT_W-1:0]     slot,
	input  wire logic [irbl_pkg::BSTART_W-1:0]   bucket_start,
	input  wire logic [irbl_pkg::IP_W-1:0]       range_end_ip,
	input  wire logic [irbl_pkg::OFF_W-1:0]      record_data_offset,
	input  wire logic [irbl_pkg::LEN_W-1:0]      record_data_length,
	input  wire logic [irbl_pkg::IP_W-1:0]       lookup_ip,
	output logic                                 done,
	output logic                                 found,
	output logic                                 status,
	output logic      [irbl_pkg::OFF_W-1:0]      data_offset,
	output logic      [irbl_pkg::LEN_W-1:0]      copy_length,
	output logic      [irbl_pkg::RECNO_W-1:0]    record_number
);

	irbl_pkg::cfg_t     cfg_q;
	irbl_pkg::ctl_cmd_t cmd;
	irbl_pkg::ctl_sts_t sts;
	logic               cfg_wr;
	logic [1:0]         reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= irbl_pkg::MODE_RESET;
			cfg_q.record_count <= irbl_pkg::RECORD_COUNT_RESET;
			cfg_q.data_end <= irbl_pkg::DATA_END_RESET;
			cfg_q.out_capacity <= irbl_pkg::OUT_CAPACITY_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				irbl_pkg::REG_MODE: cfg_q.mode <= pwdata[0];
				irbl_pkg::REG_RECORD_COUNT:
					cfg_q.record_count <= pwdata[irbl_pkg::RCNT_W-1:0];
				irbl_pkg::REG_DATA_END: cfg_q.data_end <= pwdata[irbl_pkg::DEND_W-1:0];
				irbl_pkg::REG_OUT_CAPACITY:
					cfg_q.out_capacity <= pwdata[irbl_pkg::CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			irbl_pkg::REG_MODE: prdata = irbl_pkg::PDATA_W'(cfg_q.mode);
			irbl_pkg::REG_RECORD_COUNT: prdata = irbl_pkg::PDATA_W'(cfg_q.record_count);
			irbl_pkg::REG_DATA_END: prdata = irbl_pkg::PDATA_W'(cfg_q.data_end);
			irbl_pkg::REG_OUT_CAPACITY: prdata = irbl_pkg::PDATA_W'(cfg_q.out_capacity);
			default: prdata = '0;
		endcase
	end

	irbl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	irbl_dp #(.RECORD_DEPTH(RECORD_DEPTH), .BUCKET_DEPTH(BUCKET_DEPTH)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.cmd                (cmd),
		.sts                (sts),
		.opcode             (opcode),
		.slot               (slot),
		.bucket_start       (bucket_start),
		.range_end_ip       (range_end_ip),
		.record_data_offset (record_data_offset),
		.record_data_length (record_data_length),
		.lookup_ip          (lookup_ip),
		.done               (done),
		.found              (found),
		.status             (status),
		.data_offset        (data_offset),
		.copy_length        (copy_length),
		.record_number      (record_number)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a lookup in flight");

	a_lookup_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == irbl_pkg::OP_LOOKUP) |=> busy)
		else $error("lookup accepted but core not busy");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (!status && copy_length == '0 && data_offset == '0
			&& record_number == '0))
		else $error("not-found result carries data");

	a_bound_err: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (found && copy_length == '0))
		else $error("bound error result malformed");

endmodule
`default_nettype wire

FILE: bench/irbl_checker.sv
// Lookup checker for the IPv4 range bucket lookup core: follows table and register writes,
// predicts every lookup result and compares it with the result strobe of the block.
// Depends on irbl_pkg only.
`default_nettype none
module irbl_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic                       pready,
	input  wire logic [irbl_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [irbl_pkg::PDATA_W-1:0]  pwdata,
	input  wire logic                       start,
	input  wire logic                       busy,
	input  wire logic [irbl_pkg::OPC_W-1:0]    opcode,
	input  wire logic [irbl_pkg::SLOT_W-1:0]   slot,
	input  wire logic [irbl_pkg::BSTART_W-1:0] bucket_start,
	input  wire logic [irbl_pkg::IP_W-1:0]     range_end_ip,
	input  wire logic [irbl_pkg::OFF_W-1:0]    record_data_offset,
	input  wire logic [irbl_pkg::LEN_W-1:0]    record_data_length,
	input  wire logic [irbl_pkg::IP_W-1:0]     lookup_ip,
	input  wire logic                       done,
	input  wire logic                       found,
	input  wire logic                       status,
	input  wire logic [irbl_pkg::OFF_W-1:0]    data_offset,
	input  wire logic [irbl_pkg::LEN_W-1:0]    copy_length,
	input  wire logic [irbl_pkg::RECNO_W-1:0]  record_number,
	output int                              fail_count,
	output int                              pending
);
	import irbl_pkg::*;

	typedef struct packed {
		logic found;
		logic status;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
		logic [RECNO_W-1:0] recno;
	} lookup_res_t;

	logic [BSTART_W-1:0] bucket_first [int];
	logic [IP_W-1:0] record_end_ip [int];
	logic [LOC_W-1:0] record_loc [int];

	logic cfg_mode;
	logic [RCNT_W-1:0] cfg_record_count;
	logic [DEND_W-1:0] cfg_data_end;
	logic [CAP_W-1:0] cfg_out_capacity;

	lookup_res_t lookup_q [$];
	int mismatches = 0;

	assign fail_count = mismatches;

	function automatic lookup_res_t predict_lookup(input logic [IP_W-1:0] ip);
		lookup_res_t r;
		longint unsigned bkt;
		longint unsigned idx;
		longint unsigned scan_end;
		longint unsigned off;
		longint unsigned len;
		longint unsigned lim;
		logic [IP_W-1:0] end_v;
		logic [LOC_W-1:0] loc;
		r = '0;
		bkt = cfg_mode ? 64'(ip[31:16]) : 64'(ip[31:24]);
		if (bkt >= BUCKET_DEPTH)
			return r;
		scan_end = (cfg_record_count > RECORD_DEPTH) ? 64'(RECORD_DEPTH)
			: 64'(cfg_record_count);
		idx = bucket_first.exists(int'(bkt)) ? 64'(bucket_first[int'(bkt)]) : 64'd0;
		while (idx < scan_end) begin
			end_v = record_end_ip.exists(int'(idx)) ? record_end_ip[int'(idx)] : '0;
			if (end_v >= ip) begin
				loc = record_loc.exists(int'(idx)) ? record_loc[int'(idx)] : '0;
				off = 64'(loc[OFF_W-1:0]);
				len = 64'(loc[LOC_W-1:OFF_W]);
				r.found = 1'b1;
				r.offset = OFF_W'(off);
				r.recno = RECNO_W'(idx);
				if (cfg_mode && off + len > 64'(cfg_data_end)) begin
					r.status = 1'b1;
					return r;
				end
				lim = (cfg_out_capacity == '0) ? 64'd0 : 64'(cfg_out_capacity) - 64'd1;
				r.length = LEN_W'((len > lim) ? lim : len);
				return r;
			end
			idx++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_res_t want_r;
		lookup_res_t got_r;
		if (!arst_n) begin
			cfg_mode <= MODE_RESET;
			cfg_record_count <= RECORD_COUNT_RESET;
			cfg_data_end <= DATA_END_RESET;
			cfg_out_capacity <= OUT_CAPACITY_RESET;
			lookup_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				got_r = {found, status, data_offset, copy_length, record_number};
				if (lookup_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: lookup result with none outstanding", $time);
				end else begin
					want_r = lookup_q.pop_front();
					if (got_r !== want_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: lookup mismatch want found=%0d status=%0d off=%h ",
								$time, want_r.found, want_r.status, want_r.offset,
								"len=%h rec=%h / got found=%0d status=%0d off=%h len=%h rec=%h",
								want_r.length, want_r.recno, got_r.found, got_r.status,
								got_r.offset, got_r.length, got_r.recno);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MODE: cfg_mode <= pwdata[0];
					REG_RECORD_COUNT: cfg_record_count <= pwdata[RCNT_W-1:0];
					REG_DATA_END: cfg_data_end <= pwdata[DEND_W-1:0];
					REG_OUT_CAPACITY: cfg_out_capacity <= pwdata[CAP_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (opcode)
					OP_WR_BUCKET: begin
						if (slot < BUCKET_DEPTH)
							bucket_first[int'(slot)] = bucket_start;
					end
					OP_WR_RECORD: begin
						if (slot < RECORD_DEPTH) begin
							record_end_ip[int'(slot)] = range_end_ip;
							record_loc[int'(slot)] = {record_data_length, record_data_offset};
						end
					end
					OP_LOOKUP: lookup_q.push_back(predict_lookup(lookup_ip));
					default: ;
				endcase
			end
			pending <= lookup_q.size();
		end
	end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Top of the lookup core bench: clock, reset, table and register stimulus, verdict.
// Depends on irbl_pkg, ip_range_bucket_lookup_core and irbl_checker.
`default_nettype none
module testbench;
	import irbl_pkg::*;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_GOAL = 450;
	localparam int DATA_END_MAX = 16842750;
	localparam int CAPACITY_MAX = 65536;
	localparam logic [BSTART_W-1:0] START_PAST_END = 20'h80000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [OPC_W-1:0] opcode;
	logic [SLOT_W-1:0] slot;
	logic [BSTART_W-1:0] bucket_start;
	logic [IP_W-1:0] range_end_ip;
	logic [OFF_W-1:0] record_data_offset;
	logic [LEN_W-1:0] record_data_length;
	logic [IP_W-1:0] lookup_ip;
	logic done;
	logic found;
	logic status;
	logic [OFF_W-1:0] data_offset;
	logic [LEN_W-1:0] copy_length;
	logic [RECNO_W-1:0] record_number;
	int fail_count;
	int pending;

	logic [IP_W-1:0] rec_end [int];
	bit block_last [int];
	bit bucket_set [int];
	int blk_base [$];
	int blk_len [$];
	logic cur_mode;
	int idle_pct;
	int item_count;

	ip_range_bucket_lookup_core uut (.*);
	irbl_checker lookup_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send(input logic [OPC_W-1:0] op, input logic [SLOT_W-1:0] s,
			input logic [BSTART_W-1:0] bs, input logic [IP_W-1:0] re,
			input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len,
			input logic [IP_W-1:0] ip);
		start <= 1'b1;
		opcode <= op;
		slot <= s;
		bucket_start <= bs;
		range_end_ip <= re;
		record_data_offset <= off;
		record_data_length <= len;
		lookup_ip <= ip;
		do @(posedge clk); while (busy);
		item_count++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic put_bucket(input int b, input logic [BSTART_W-1:0] st);
		bucket_set[b] = 1'b1;
		send(OP_WR_BUCKET, b, st, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic wr_record(input int s, input logic [IP_W-1:0] re,
			input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
		if (block_last.exists(s))
			re = 32'hFFFF_FFFF;
		rec_end[s] = re;
		send(OP_WR_RECORD, s, $urandom, re, off, len, $urandom);
	endtask

	function automatic logic [LEN_W-1:0] rand_length();
		return $urandom_range(1) ? $urandom_range(0, 700) : $urandom_range(0, 65535);
	endfunction

	function automatic logic [BSTART_W-1:0] pick_start();
		int k;
		if ($urandom_range(9) == 0)
			return START_PAST_END;
		k = $urandom_range(blk_base.size() - 1);
		return blk_base[k] + $urandom_range(blk_len[k] - 1);
	endfunction

	task automatic add_block(input int base, input int len);
		blk_base.push_back(base);
		blk_len.push_back(len);
		block_last[base + len - 1] = 1'b1;
		for (int i = 0; i < len; i++)
			wr_record(base + i, $urandom, $urandom, rand_length());
	endtask

	task automatic look(input logic [IP_W-1:0] ip);
		int b;
		b = cur_mode ? int'(ip[31:16]) : int'(ip[31:24]);
		if (!bucket_set.exists(b))
			put_bucket(b, pick_start());
		send(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, ip);
	endtask

	// aim a bucket at a block and look up just around one of its end addresses
	task automatic look_near();
		int k;
		int i;
		int b;
		logic [IP_W-1:0] e;
		logic [IP_W-1:0] ip;
		k = $urandom_range(blk_base.size() - 1);
		i = $urandom_range(blk_len[k] - 1);
		e = rec_end[blk_base[k] + i];
		case ($urandom_range(2))
			0: ip = e - 1;
			1: ip = e;
			default: ip = e + 1;
		endcase
		b = cur_mode ? int'(ip[31:16]) : int'(ip[31:24]);
		put_bucket(b, blk_base[k] + $urandom_range(i));
		send(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, ip);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_config(input logic m, input int rc, input int de, input int cap);
		drain();
		write_reg(REG_MODE, m);
		write_reg(REG_RECORD_COUNT, rc);
		write_reg(REG_DATA_END, de);
		write_reg(REG_OUT_CAPACITY, cap);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_mode = m;
	endtask

	task automatic random_config();
		int rc;
		int de;
		int cap;
		case ($urandom_range(7))
			0, 1, 2, 3: rc = RECORD_DEPTH;
			4: rc = 0;
			5: rc = $urandom_range(0, RECORD_DEPTH);
			default: rc = $urandom_range(0, 64);
		endcase
		case ($urandom_range(3))
			0: de = DATA_END_MAX;
			1: de = 0;
			default: de = $urandom_range(0, DATA_END_MAX);
		endcase
		case ($urandom_range(5))
			0: cap = 1;
			1: cap = CAPACITY_MAX;
			2: cap = 0;
			3: cap = $urandom_range(1, CAPACITY_MAX);
			default: cap = $urandom_range(1, 1024);
		endcase
		set_config($urandom_range(1), rc, de, cap);
	endtask

	initial begin : stimulus
		int roll;
		int len;
		int next_cfg_at;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		opcode = OP_WR_BUCKET;
		slot = '0;
		bucket_start = '0;
		range_end_ip = '0;
		record_data_offset = '0;
		record_data_length = '0;
		lookup_ip = '0;
		idle_pct = 23;
		item_count = 0;
		cur_mode = MODE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(1'b1, 4, DATA_END_MAX, 512);
		blk_base.push_back(0);
		blk_len.push_back(4);
		block_last[3] = 1'b1;
		wr_record(0, 32'h0000_0000, 24'h00_0000, 16'h0000);
		wr_record(1, 32'h0A00_00FF, 24'hFF_FFFF, 16'hFFFF);
		wr_record(2, 32'h0A00_FFFF, 24'd100, 16'd600);
		wr_record(3, 32'hFFFF_FFFF, 24'd1000, 16'd50);
		put_bucket(16'h0000, 0);
		put_bucket(16'h0A00, 1);
		put_bucket(16'hFFFF, 3);
		put_bucket(16'h0B00, START_PAST_END);
		send(OP_WR_BUCKET, 19'h7FFFF, 20'hFFFFF, '1, '1, '1, '1);
		send(OP_UNUSED, '1, '1, '1, '1, '1, '1);
		look(32'h0000_0000);
		look(32'h0A00_0005);
		look(32'h0A00_0100);
		look(32'hFFFF_FFFF);
		look(32'h0B00_1234);
		set_config(1'b1, RECORD_DEPTH, 0, CAPACITY_MAX);
		look(32'h0A00_0005);
		look(32'h0000_0000);
		look(32'hFFFF_FFFF);
		set_config(1'b0, 2, DATA_END_MAX, 0);
		put_bucket(8'h0A, 1);
		look(32'h0A00_0001);
		put_bucket(8'hFF, 3);
		look(32'hFF00_0000);

		set_config(1'b1, RECORD_DEPTH, DATA_END_MAX, 512);
		add_block(RECORD_DEPTH - 12, 12);
		len = $urandom_range(2, 12);
		add_block($urandom_range(0, RECORD_DEPTH - len), len);

		next_cfg_at = item_count + 60;
		while (item_count < ITEM_GOAL) begin
			idle_pct = (item_count < 170) ? 23 : (item_count < 320) ? 72 : 0;
			if (item_count >= next_cfg_at) begin
				random_config();
				next_cfg_at = item_count + 60;
			end
			roll = $urandom_range(99);
			if (roll < 30) begin
				look($urandom);
			end else if (roll < 55) begin
				look_near();
			end else if (roll < 70) begin
				len = $urandom_range(blk_base.size() - 1);
				wr_record(blk_base[len] + $urandom_range(blk_len[len] - 1), $urandom,
					$urandom, rand_length());
			end else if (roll < 80) begin
				put_bucket($urandom_range(BUCKET_DEPTH - 1), pick_start());
			end else if (roll < 85) begin
				send(OP_WR_BUCKET, $urandom_range(BUCKET_DEPTH, 524287), $urandom, $urandom,
					$urandom, $urandom, $urandom);
			end else if (roll < 90) begin
				send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else if (roll < 94) begin
				len = $urandom_range(2, 12);
				add_block($urandom_range(0, RECORD_DEPTH - len), len);
			end else begin
				wr_record($urandom_range(RECORD_DEPTH - 1), $urandom, $urandom, rand_length());
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
sv/irbl_pkg.sv
sv/irbl_ram.sv
sv/irbl_ctrl.sv
sv/irbl_dp.sv
sv/ip_range_bucket_lookup_core.sv
bench/irbl_checker.sv
bench/testbench.sv
